// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the product-except-self scan core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/pesc_pkg.sv
// Package: sizes and types of the product-except-self scan core.
package pesc_pkg;

    // List capacity and the widths that follow from it
    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int DATA_W  = 32;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

endpackage

// File: hw/rtl/pesc_if.sv
// Interfaces: element request channel and result request channel.
interface pesc_in_if;
    import pesc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;
    logic                     last_element;

    modport source (output valid, element_value, last_element, input ready);
    modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface pesc_out_if;
    import pesc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] product_value;
    logic                     last_result;
    logic                     truncated;

    modport source (output valid, product_value, last_result, truncated, input ready);
    modport sink   (input valid, product_value, last_result, truncated, output ready);
endinterface

// File: hw/rtl/product_except_self_scan_core.sv
// Top level: product-except-self scan core with element and result memories.
//
// The core collects a list of signed 32-bit elements, one request per cycle,
// up to MAX_LEN (64) entries; further elements are dropped and every result of
// that list carries the truncated flag. The request with last_element set
// closes the list. The core then runs a forward prefix-product pass and a
// backward suffix-product pass over the element memory, one entry per cycle
// each, and then emits the n products in list order, each read from the
// result memory, loaded into the output register and held until o_res.ready
// takes it. Products wrap modulo 2^32. No input request is taken while a list
// is being processed or emitted. No clearing pass is needed after reset.
module product_except_self_scan_core
    import pesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pesc_in_if.sink    i_elem,
    pesc_out_if.source o_res
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FWD,
        S_BWD,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    localparam t_count MaxCnt = CNT_W'(MAX_LEN);

    // Memories
    t_word elem_mem [MAX_LEN];
    t_word res_mem  [MAX_LEN];

    // Control and datapath registers
    t_state r_state;
    t_count r_cnt;
    t_count r_idx;
    logic   r_ovf;
    t_word  r_run;
    logic   r_pend;
    logic   r_plast;
    t_addr  r_paddr;
    t_word  r_elem_q;
    t_word  r_res_q;
    logic   r_o_valid;
    t_word  r_o_prod;
    logic   r_o_last;
    logic   r_o_trunc;

    // Combinational controls
    logic        in_acc;
    logic        out_acc;
    logic        elem_we;
    logic        issue;
    t_count      rd_idx;
    t_addr       rd_addr;
    logic        res_we;
    t_word       res_wdata;
    t_word       run_prod;
    t_word       res_prod;

    assign i_elem.ready        = (r_state == S_LOAD);
    assign o_res.valid         = r_o_valid;
    assign o_res.product_value = r_o_prod;
    assign o_res.last_result   = r_o_last;
    assign o_res.truncated     = r_o_trunc;

    assign in_acc  = i_elem.valid && i_elem.ready;
    assign out_acc = o_res.valid && o_res.ready;

    // Multiply the running product by the element and the partial result, low word only
    assign run_prod = r_run * r_elem_q;
    assign res_prod = r_res_q * r_run;

    // Select read address, issue and write-back
    always_comb begin
        elem_we = in_acc && (r_cnt < MaxCnt);
        rd_idx  = r_idx;
        issue   = 1'b0;
        if (r_state == S_FWD) begin
            issue = (r_idx != r_cnt);
        end else if (r_state == S_BWD) begin
            rd_idx = r_idx - CNT_W'(1);
            issue  = (r_idx != '0);
        end
        rd_addr   = rd_idx[ADDR_W-1:0];
        res_we    = r_pend;
        res_wdata = (r_state == S_FWD) ? r_run : res_prod;
    end

    // Element memory: write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            elem_mem[r_cnt[ADDR_W-1:0]] <= t_word'(i_elem.element_value);
        end
        r_elem_q <= elem_mem[rd_addr];
    end

    // Result memory: write back pending pass results, read every cycle
    always_ff @(posedge i_clk) begin
        if (res_we) begin
            res_mem[r_paddr] <= res_wdata;
        end
        r_res_q <= res_mem[rd_addr];
    end

    // Sequence load, both passes and the result stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_ovf     <= 1'b0;
            r_run     <= DATA_W'(1);
            r_pend    <= 1'b0;
            r_plast   <= 1'b0;
            r_paddr   <= '0;
            r_o_valid <= 1'b0;
            r_o_prod  <= '0;
            r_o_last  <= 1'b0;
            r_o_trunc <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (elem_we) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_elem.last_element) begin
                            r_state <= S_FWD;
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_run   <= DATA_W'(1);
                        end
                    end
                end
                S_FWD: begin
                    // Advance reads in ascending order, fold in the arriving element
                    if (r_pend && r_plast) begin
                        r_state <= S_BWD;
                        r_idx   <= r_cnt;
                        r_pend  <= 1'b0;
                        r_run   <= DATA_W'(1);
                    end else begin
                        r_pend  <= issue;
                        r_paddr <= rd_addr;
                        r_plast <= (rd_idx == r_cnt - CNT_W'(1));
                        if (issue) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                        if (r_pend) begin
                            r_run <= run_prod;
                        end
                    end
                end
                S_BWD: begin
                    // Walk down, multiply in the suffix product
                    if (r_pend && r_plast) begin
                        r_state <= S_EMIT_RD;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                    end else begin
                        r_pend  <= issue;
                        r_paddr <= rd_addr;
                        r_plast <= (rd_idx == '0);
                        if (issue) begin
                            r_idx <= rd_idx;
                        end
                        if (r_pend) begin
                            r_run <= run_prod;
                        end
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_o_valid <= 1'b1;
                    r_o_prod  <= r_res_q;
                    r_o_last  <= (r_idx == r_cnt - CNT_W'(1));
                    r_o_trunc <= r_ovf;
                    r_state   <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    // Hold the result until taken, then drop the list or go on
                    if (out_acc) begin
                        r_o_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_LOAD;
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_run   <= DATA_W'(1);
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    `include "assert_macros.svh"

    `PESC_ASSERT(a_no_take_while_emit, o_res.valid |-> !i_elem.ready, "element taken during emit")
    `PESC_ASSERT(a_cnt_in_range, r_cnt <= MaxCnt, "element count beyond capacity")
    `PESC_ASSERT(a_clear_after_run, (out_acc && o_res.last_result) |=> (r_cnt == '0 && !r_ovf), "list state not cleared after run")
    `PESC_ASSERT_ALWAYS(a_pend_in_pass, r_pend |-> (r_state == S_FWD || r_state == S_BWD), "pending write outside a pass")

endmodule
